### sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants
// Field widths, operation codes and result status codes for the sorted table
// bracket search block.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int KEY_W    = 32;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int STATUS_W = 3;

   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam status_type ST_MATCH   = 3'd0;
   localparam status_type ST_BRACKET = 3'd1;
   localparam status_type ST_BELOW   = 3'd2;
   localparam status_type ST_ABOVE   = 3'd3;
   localparam status_type ST_EMPTY   = 3'd4;

endpackage

### sv/stbs_mem.sv
// ----------------------------------------------------------------------------
// stbs_mem: table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  stbs_pkg::key_type       wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output stbs_pkg::key_type       rd_data
);
   import stbs_pkg::*;

   key_type table_q [DEPTH];
   key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_q[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/stbs_engine.sv
// ----------------------------------------------------------------------------
// stbs_engine: search sequencer
// Accepts transactions, writes table entries, runs the end checks and the
// halving probe loop against the table memory, and holds the result register.
// ----------------------------------------------------------------------------
module stbs_engine #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int LW    = 11
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  stbs_pkg::idx_type       req_entry_index,
   input  stbs_pkg::key_type       req_key_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output stbs_pkg::status_type    rsp_status,
   output stbs_pkg::idx_type       rsp_lower_index,
   output stbs_pkg::idx_type       rsp_upper_index,
   input  logic                    csr_wr_en,
   input  stbs_pkg::cnt_type       csr_wr_data,
   output logic                    mem_wr_en,
   output logic [AW-1:0]           mem_wr_addr,
   output stbs_pkg::key_type       mem_wr_data,
   output logic                    mem_rd_en,
   output logic [AW-1:0]           mem_rd_addr,
   input  stbs_pkg::key_type       mem_rd_data
);
   import stbs_pkg::*;

   localparam int CW = (LW > CNT_W) ? LW : CNT_W;
   localparam int OW = (LW > IDX_W) ? LW : IDX_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIRST = 3'd1;
   localparam logic [2:0] S_LAST  = 3'd2;
   localparam logic [2:0] S_ISSUE = 3'd3;
   localparam logic [2:0] S_CMP   = 3'd4;

   logic [2:0]  state_ff, state_in;
   cnt_type     count_ff;
   key_type     key_ff, key_in;
   logic [LW-1:0] low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   idx_type     rsp_lower_ff, rsp_lower_in, rsp_upper_ff, rsp_upper_in;

   logic        out_full, accept, fin;
   status_type  fin_status;
   idx_type     fin_lower, fin_upper;
   logic [LW-1:0] len, len_m1, mid_calc;
   logic [OW-1:0] low_ext;

   // count above the table depth saturates
   assign len = (CW'(count_ff) > CW'(DEPTH)) ? LW'(DEPTH) : LW'(count_ff);
   assign len_m1   = len - LW'(1);
   assign mid_calc = low_ff + ((high_ff - low_ff) >> 1);
   assign low_ext  = OW'(low_ff);

   assign out_full  = rsp_valid_ff & rsp_stall;
   assign req_stall = (state_ff != S_IDLE) | out_full;
   assign accept    = req_valid & ~req_stall;

   // writes happen only in idle, reads only during a search: no overlap
   assign mem_wr_addr = AW'(req_entry_index);
   assign mem_wr_data = req_key_value;

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      mid_in     = mid_ff;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      mem_rd_addr = '0;
      fin        = 1'b0;
      fin_status = ST_EMPTY;
      fin_lower  = '0;
      fin_upper  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_WRITE) begin
                  mem_wr_en = (32'(req_entry_index) < 32'(DEPTH));
               end else begin
                  key_in = req_key_value;
                  if (len == '0) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = S_FIRST;
                  end
               end
            end
         end
         S_FIRST: begin
            if (key_ff < mem_rd_data) begin
               fin        = 1'b1;
               fin_status = ST_BELOW;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = len_m1[AW-1:0];
               state_in    = S_LAST;
            end
         end
         S_LAST: begin
            if (key_ff > mem_rd_data) begin
               fin        = 1'b1;
               fin_status = ST_ABOVE;
            end else begin
               low_in   = '0;
               high_in  = len_m1;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (low_ff <= high_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_calc[AW-1:0];
               mid_in      = mid_calc;
               state_in    = S_CMP;
            end else begin
               fin        = 1'b1;
               fin_status = ST_BRACKET;
               fin_lower  = 10'(low_ext - OW'(1));
               fin_upper  = 10'(low_ext);
            end
         end
         S_CMP: begin
            if (mem_rd_data == key_ff) begin
               fin        = 1'b1;
               fin_status = ST_MATCH;
               fin_lower  = 10'(OW'(mid_ff));
               fin_upper  = 10'(OW'(mid_ff));
            end else if (mem_rd_data < key_ff) begin
               low_in   = mid_ff + LW'(1);
               state_in = S_ISSUE;
            end else if (mid_ff == '0) begin
               // probe at index zero too large: range cannot shrink further
               fin        = 1'b1;
               fin_status = ST_BRACKET;
               fin_lower  = 10'(low_ext - OW'(1));
               fin_upper  = 10'(low_ext);
            end else begin
               high_in  = mid_ff - LW'(1);
               state_in = S_ISSUE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_lower_in  = rsp_lower_ff;
      rsp_upper_in  = rsp_upper_ff;
      // a finished search waits in its state until the result slot frees up
      if (fin && !out_full) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = fin_status;
         rsp_lower_in  = fin_lower;
         rsp_upper_in  = fin_upper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin && !out_full) begin
            state_ff <= S_IDLE;
         end else begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      low_ff        <= low_in;
      high_ff       <= high_in;
      mid_ff        <= mid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lower_ff  <= rsp_lower_in;
      rsp_upper_ff  <= rsp_upper_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_lower_index = rsp_lower_ff;
   assign rsp_upper_index = rsp_upper_ff;

endmodule

### sv/sorted_table_bracket_search.sv
// ----------------------------------------------------------------------------
// sorted_table_bracket_search: sorted table with bracketing key search
// Table of 32-bit entries in one synchronous memory, searched by halving.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel (valid/stall): opcode 0 writes req_key_value at
//   req_entry_index, no response; opcode 1 searches for req_key_value among
//   the first entries_in_use entries and returns one rsp_* transaction.
//   csr_wr_en/csr_wr_data load entries_in_use; write it only while idle.
// Sequence:
//   A write is done when accepted. An empty-table search answers from the
//   idle state; any other search first reads and compares entry 0, then the
//   last entry in use, and answers BELOW or ABOVE if the key is out of range.
//   Inside the range it probes by halving: each probe is one memory read
//   plus one compare on the single read port.
//   One transaction is worked on at a time; req_stall is high while a search
//   runs or while a finished response is held by rsp_stall.
// Reset:
//   Synchronous, active high; clears the sequencer, the response valid and
//   entries_in_use. Table contents are not cleared and must be written
//   before they are searched.
// ----------------------------------------------------------------------------
module sorted_table_bracket_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  stbs_pkg::idx_type       req_entry_index,
   input  stbs_pkg::key_type       req_key_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output stbs_pkg::status_type    rsp_status,
   output stbs_pkg::idx_type       rsp_lower_index,
   output stbs_pkg::idx_type       rsp_upper_index,
   input  logic                    csr_wr_en,
   input  stbs_pkg::cnt_type       csr_wr_data
);
   import stbs_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = $clog2(TABLE_DEPTH + 1);

   logic          mem_wr_en, mem_rd_en;
   logic [AW-1:0] mem_wr_addr, mem_rd_addr;
   key_type       mem_wr_data, mem_rd_data;

   stbs_engine #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW),
      .LW    (LW)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_key_value   (req_key_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_lower_index (rsp_lower_index),
      .rsp_upper_index (rsp_upper_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   stbs_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### sv/stbs_chk.sv
// ----------------------------------------------------------------------------
// stbs_chk: port-level checker
// Checks response codes and index pairs seen on the top-level ports.
// ----------------------------------------------------------------------------
module stbs_chk (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  stbs_pkg::status_type    rsp_status,
   input  stbs_pkg::idx_type       rsp_lower_index,
   input  stbs_pkg::idx_type       rsp_upper_index
);
   import stbs_pkg::*;

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_lower_index) && $stable(rsp_upper_index))
      else $error("response changed while stalled");

   a_match_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MATCH |-> rsp_lower_index == rsp_upper_index)
      else $error("match bounds differ");

   a_bracket_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BRACKET
         |-> idx_type'(rsp_lower_index + 10'd1) == rsp_upper_index)
      else $error("bracket bounds not adjacent");

   a_edge_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BELOW || rsp_status == ST_ABOVE
         || rsp_status == ST_EMPTY) |-> rsp_lower_index == '0 && rsp_upper_index == '0)
      else $error("nonzero index on out-of-range response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_MATCH || rsp_status == ST_BRACKET
         || rsp_status == ST_BELOW || rsp_status == ST_ABOVE || rsp_status == ST_EMPTY)
      else $error("undefined status code");

endmodule

bind sorted_table_bracket_search stbs_chk u_stbs_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_lower_index (rsp_lower_index),
   .rsp_upper_index (rsp_upper_index)
);

### test/sorted_table_bracket_search_test.sv
// ----------------------------------------------------------------------------
// sorted_table_bracket_search_test: self-checking bench for the search block
// Walks a short directed table (empty table, range ends, exact hits, unsorted
// content), then fills the whole table and runs random phases of entry count
// settings, table rewrites and searches. Each search response is checked
// against a local predictor of the halving search or a typed row's expectation.
// Requests idle, responses stall at random and once hold off for a long stretch.
// ----------------------------------------------------------------------------
module sorted_table_bracket_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   import stbs_pkg::*;

   localparam int DEPTH         = 1024;
   localparam int DIRECTED_ROWS = 23;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      status_type status;
      idx_type    lower;
      idx_type    upper;
   } search_result_type;

   typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_SEARCH} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      cnt_type      count;
      idx_type      index;
      key_type      key;
      logic         typed;
      status_type   exp_status;
      idx_type      exp_lower;
      idx_type      exp_upper;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_opcode;
   idx_type    req_entry_index;
   key_type    req_key_value;
   logic       rsp_valid;
   logic       rsp_stall;
   status_type rsp_status;
   idx_type    rsp_lower_index;
   idx_type    rsp_upper_index;
   logic       csr_wr_en;
   cnt_type    csr_wr_data;

   // bench copy of the table and of the entry count register
   key_type           table_image [DEPTH];
   int unsigned       image_count = 0;
   search_result_type pending_answers [$];

   int  failures        = 0;
   int  answers_checked = 0;
   int  items_sent      = 0;
   bit  quiet_tx        = 1'b0;
   bit  quiet_rx        = 1'b0;
   bit  long_hold_done  = 1'b0;

   // typed rows carry an expectation that can be read straight off the table
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0000, 1'b1, ST_EMPTY,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'hFFFF_FFFF, 1'b1, ST_EMPTY,   10'd0, 10'd0},
      '{ROW_WRITE,  11'd0, 10'd0, 32'h0000_0010, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_WRITE,  11'd0, 10'd1, 32'h0000_0100, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_WRITE,  11'd0, 10'd2, 32'h0000_1000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_WRITE,  11'd0, 10'd3, 32'hFFFF_FFFE, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_CFG,    11'd4, 10'd0, 32'h0000_0000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0000, 1'b1, ST_BELOW,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'hFFFF_FFFF, 1'b1, ST_ABOVE,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0010, 1'b1, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'hFFFF_FFFE, 1'b1, ST_MATCH,   10'd3, 10'd3},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0100, 1'b1, ST_MATCH,   10'd1, 10'd1},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0800, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0011, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_1000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_CFG,    11'd1, 10'd0, 32'h0000_0000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0010, 1'b1, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_0011, 1'b1, ST_ABOVE,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_000F, 1'b1, ST_BELOW,   10'd0, 10'd0},
      '{ROW_CFG,    11'd4, 10'd0, 32'h0000_0000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      // out of order entry: the halving path no longer brackets the key
      '{ROW_WRITE,  11'd0, 10'd1, 32'h0000_2000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_1000, 1'b0, ST_MATCH,   10'd0, 10'd0},
      '{ROW_SEARCH, 11'd0, 10'd0, 32'h0000_2000, 1'b0, ST_MATCH,   10'd0, 10'd0}
   };

   sorted_table_bracket_search #(
      .TABLE_DEPTH (DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_key_value   (req_key_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_lower_index (rsp_lower_index),
      .rsp_upper_index (rsp_upper_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

   // halving search over the first image_count entries (saturated to DEPTH)
   function automatic search_result_type predict_bracket(key_type key);
      search_result_type res;
      int unsigned       n;
      int unsigned       lo;
      int unsigned       hi;
      int unsigned       mid;
      res = '{ST_EMPTY, idx_type'(0), idx_type'(0)};
      n = (image_count > DEPTH) ? DEPTH : image_count;
      if (n == 0) return res;
      if (key < table_image[0]) begin
         res.status = ST_BELOW;
         return res;
      end
      if (key > table_image[n - 1]) begin
         res.status = ST_ABOVE;
         return res;
      end
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (table_image[mid] == key) begin
            res = '{ST_MATCH, idx_type'(mid), idx_type'(mid)};
            return res;
         end else if (table_image[mid] < key) begin
            lo = mid + 1;
         end else begin
            if (mid == 0) break;
            hi = mid - 1;
         end
      end
      // both bounds wrap at the index width
      res = '{ST_BRACKET, idx_type'(lo - 1), idx_type'(lo)};
      return res;
   endfunction

   // offer one transaction after a random gap and wait for it to be taken
   task automatic send_item(logic op, idx_type idx, key_type key);
      int unsigned gap;
      int unsigned r;
      gap = 0;
      if (!quiet_tx) begin
         r = $urandom_range(0, 99);
         if (r >= 98)      gap = $urandom_range(20, 60);
         else if (r >= 90) gap = $urandom_range(4, 10);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= idx;
      req_key_value   <= key;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      if (op == OP_WRITE) begin
         table_image[idx] = key;
      end else begin
         pending_answers.push_back(predict_bracket(key));
      end
   endtask

   // stop offering, let every response come back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(cnt_type count);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      image_count = count;
   endtask

   // response side stall pattern, with one forced long hold
   initial begin
      int unsigned hold;
      int unsigned r;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         hold = 0;
         if (!long_hold_done && answers_checked >= 30) begin
            long_hold_done = 1'b1;
            hold = 300;
         end else if (!quiet_rx) begin
            r = $urandom_range(0, 999);
            if (r >= 998)      hold = $urandom_range(100, 200);
            else if (r >= 950) hold = $urandom_range(4, 40);
            else if (r >= 650) hold = $urandom_range(1, 3);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      search_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         answers_checked++;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response status %0d lower %0d upper %0d",
                     $time, rsp_status, rsp_lower_index, rsp_upper_index);
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_status);
               failures++;
            end
            if (rsp_lower_index !== want.lower) begin
               $display("%0t: lower_index expected %0d, got %0d",
                        $time, want.lower, rsp_lower_index);
               failures++;
            end
            if (rsp_upper_index !== want.upper) begin
               $display("%0t: upper_index expected %0d, got %0d",
                        $time, want.upper, rsp_upper_index);
               failures++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int unsigned  count;
      int unsigned  n;
      int unsigned  m;
      int unsigned  r;
      int unsigned  j;
      int unsigned  step_max;
      int unsigned  burst;
      key_type      v;
      key_type      lo_b;
      key_type      hi_b;
      idx_type      idx;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_WRITE;
      req_entry_index <= '0;
      req_key_value   <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         unique case (row.kind)
            ROW_CFG: begin
               set_entry_count(row.count);
            end
            ROW_WRITE: begin
               send_item(OP_WRITE, row.index, row.key);
            end
            default: begin
               send_item(OP_SEARCH, row.index, row.key);
               if (row.typed) begin
                  void'(pending_answers.pop_back());
                  pending_answers.push_back(search_result_type'{row.exp_status,
                                            row.exp_lower, row.exp_upper});
               end
            end
         endcase
      end

      // fill the whole table in ascending order, top bits track the index
      set_entry_count(cnt_type'(DEPTH));
      for (int i = 0; i < DEPTH; i++) begin
         send_item(OP_WRITE, idx_type'(i), key_type'((i << 22) | $urandom_range(0, 22'h3F_FFFF)));
      end
      for (int i = 0; i < 40; i++) begin
         j = $urandom_range(0, DEPTH - 1);
         r = $urandom_range(0, 3);
         v = (r == 0) ? key_type'($urandom) : table_image[j] + key_type'(r - 1);
         send_item(OP_SEARCH, idx_type'($urandom), v);
      end

      while (items_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8)       count = 0;
         else if (r < 16) count = 1;
         else if (r < 22) count = 2;
         else if (r < 28) count = DEPTH;
         else if (r < 32) count = $urandom_range(DEPTH + 1, 2047);
         else if (r < 36) count = 2047;
         else if (r < 50) count = $urandom_range(65, DEPTH);
         else             count = $urandom_range(3, 64);
         set_entry_count(cnt_type'(count));
         n = (count > DEPTH) ? DEPTH : count;
         quiet_tx = ($urandom_range(0, 3) == 0);
         quiet_rx = ($urandom_range(0, 3) == 0);

         // rewrite the head of the table, mostly in order below the next entry
         m = (n > 0 && n <= 64) ? n : $urandom_range(1, 64);
         if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < m; i++) send_item(OP_WRITE, idx_type'(i), key_type'($urandom));
         end else begin
            step_max = table_image[m] / (m + 1);
            v = '0;
            for (int i = 0; i < m; i++) begin
               if ($urandom_range(0, 9) != 0) v = v + key_type'($urandom_range(0, step_max));
               send_item(OP_WRITE, idx_type'(i), v);
            end
         end

         burst = $urandom_range(20, 60);
         for (int i = 0; i < burst; i++) begin
            j = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, DEPTH - 1);
            if ($urandom_range(0, 99) < 12) begin
               // single entry update, usually kept between its neighbors
               idx  = idx_type'(j);
               lo_b = (j > 0) ? table_image[j - 1] : '0;
               hi_b = (j < DEPTH - 1) ? table_image[j + 1] : '1;
               if ($urandom_range(0, 4) != 0 && lo_b <= hi_b)
                  v = key_type'($urandom_range(hi_b, lo_b));
               else
                  v = key_type'($urandom);
               send_item(OP_WRITE, idx, v);
            end else begin
               r = $urandom_range(0, 99);
               if (n == 0 || r >= 70 && r < 80) v = key_type'($urandom);
               else if (r < 40)                 v = table_image[j];
               else if (r < 55)                 v = table_image[j] + 1;
               else if (r < 70)                 v = table_image[j] - 1;
               else if (r < 85)                 v = '0;
               else if (r < 90)                 v = '1;
               else if (r < 95)                 v = table_image[0] - 1;
               else                             v = table_image[n - 1] + 1;
               send_item(OP_SEARCH, idx_type'($urandom), v);
            end
         end
      end

      quiet_tx = 1'b0;
      drain();
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
sv/stbs_pkg.sv
sv/stbs_mem.sv
sv/stbs_engine.sv
sv/sorted_table_bracket_search.sv
sv/stbs_chk.sv
test/sorted_table_bracket_search_test.sv
